### rtl/tyi420_pkg.sv
// Package for the tiled-to-planar I420 address unit.
// Field widths, register defaults and configuration register codes.
// No dependencies.
package tyi420_pkg;

    localparam int ADDR_W       = 23;
    localparam int PIX_W        = 8;
    localparam int MB_COLS_W    = 8;
    localparam int HEIGHT_W     = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_IDX_W    = 1;
    localparam int S_TDATA_W    = 8;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 32;

    localparam int DEF_MAX_MB_COLUMNS = 128;
    localparam int DEF_MAX_HEIGHT     = 2048;

    localparam logic [MB_COLS_W-1:0] MB_COLS_RST = 8'd80;
    localparam logic [HEIGHT_W-1:0]  HEIGHT_RST  = 12'd720;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MB_COLUMNS   = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

### rtl/tiled_yuv_to_planar_i420_unit.sv
// Tiled-to-planar I420 unit: counts macroblock position per plane kind and
// gives each byte with its planar Y/U/V byte address. Uses tyi420_pkg.
//
// Pipeline: input register, then address multiply-add into the output
// register.
// Throughput: one transaction per cycle unless m_tready stalls the output;
// the single address multiplier and the three-term add set the cycle.
// Reset (aresetn low, synchronous): counters cleared, pipeline emptied,
// mb_columns = 80, frame_height = 720.
module tiled_yuv_to_planar_i420_unit #(
    parameter int MAX_MB_COLUMNS = tyi420_pkg::DEF_MAX_MB_COLUMNS,
    parameter int MAX_HEIGHT     = tyi420_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_we,
    input  logic [tyi420_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tyi420_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tyi420_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] pixel
    input  logic [tyi420_pkg::S_TUSER_W-1:0]   s_tuser,   // [0] kind, [1] frame_start
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tyi420_pkg::M_TDATA_W-1:0]   m_tdata,   // [22:0] dest_addr, [30:23] pixel_out
    output logic                               m_tuser,   // [0] in_frame
    output logic                               m_tlast    // frame_done
);
    import tyi420_pkg::*;

    localparam int MAX_H_EVEN = MAX_HEIGHT - (MAX_HEIGHT % 2);
    localparam int ROWS_MAX   = (MAX_H_EVEN + 15) / 16;
    localparam int LCOL_W     = (MAX_MB_COLUMNS > 1) ? $clog2(MAX_MB_COLUMNS) : 1;
    localparam int ROW_W      = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int CW         = $clog2(MAX_MB_COLUMNS + 1);
    localparam int HW         = $clog2(MAX_HEIGHT + 1);
    localparam int CCMP_W     = (CW > MB_COLS_W) ? CW : MB_COLS_W;
    localparam int HCMP_W     = (HW > HEIGHT_W) ? HW : HEIGHT_W;
    localparam int YW         = ((ROW_W + 4) > HW) ? (ROW_W + 4) : HW;
    localparam int MUL_W      = ROW_W + 4;
    localparam int PROD_W     = MUL_W + CW;
    localparam int WHB_W      = ((CW + HW + 4) > ADDR_W) ? (CW + HW + 4) : ADDR_W;
    localparam int WH_W       = WHB_W + 1;

    localparam logic [CCMP_W-1:0] COLS_CAP = CCMP_W'(MAX_MB_COLUMNS);
    localparam logic [HCMP_W-1:0] H_CAP    = HCMP_W'(MAX_H_EVEN);
    localparam logic [HCMP_W-1:0] H_MIN    = HCMP_W'(2);

    // configuration
    logic [MB_COLS_W-1:0] mb_cols_reg, mb_cols_next;
    logic [HEIGHT_W-1:0]  height_reg, height_next;

    logic [CCMP_W-1:0] cols_raw;
    logic [HCMP_W-1:0] h_raw;
    logic [CW-1:0]     cols_eff;
    logic [HW-1:0]     h_eff;
    logic [HW:0]       rows_eff;

    logic [WH_W-1:0]   wh_full;
    logic [ADDR_W-1:0] base_u_reg, base_u_next;
    logic [ADDR_W-1:0] base_v_reg, base_v_next;

    // counters
    logic [LCOL_W-1:0] l_col_reg, l_col_next, c_col_reg, c_col_next;
    logic [ROW_W-1:0]  l_row_reg, l_row_next, c_row_reg, c_row_next;
    logic [7:0]        l_off_reg, l_off_next;
    logic [6:0]        c_off_reg, c_off_next;

    logic              accept, in_kind, in_start;
    logic [LCOL_W-1:0] l_col_cur, c_col_cur, col_sel, col_adv;
    logic [ROW_W-1:0]  l_row_cur, c_row_cur, row_sel, row_adv;
    logic [7:0]        l_off_cur, off_sel;
    logic [6:0]        c_off_cur;
    logic [LCOL_W:0]   col_inc;
    logic [ROW_W:0]    row_inc;
    logic              mb_end, col_wrap, row_wrap, done_cur;

    // pipeline
    logic              out_ready, s1_adv;
    logic              s1_valid_reg, s1_valid_next;
    logic              m_valid_reg, m_valid_next;
    logic              s1_kind_reg, s1_done_reg;
    logic [7:0]        s1_off_reg;
    logic [LCOL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [PIX_W-1:0]  s1_pix_reg;

    logic [MUL_W-1:0]  y_luma, mul_a;
    logic [MUL_W-2:0]  cy;
    logic [LCOL_W+3:0] x_luma;
    logic [LCOL_W+2:0] cx;
    logic [PROD_W-1:0] prod;
    logic [ADDR_W-1:0] term, base_sel, x_add, addr_calc;
    logic              in_frame_calc;

    logic [ADDR_W-1:0] addr_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic              in_frame_reg, done_reg;

    // ---------------- configuration ----------------
    always_comb begin
        mb_cols_next = mb_cols_reg;
        height_next  = height_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_MB_COLUMNS:   mb_cols_next = cfg_wdata[MB_COLS_W-1:0];
                REG_FRAME_HEIGHT: height_next  = cfg_wdata[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cols_raw = CCMP_W'(mb_cols_reg);
        if (cols_raw == '0) begin
            cols_eff = CW'(1);
        end else if (cols_raw > COLS_CAP) begin
            cols_eff = CW'(COLS_CAP);
        end else begin
            cols_eff = CW'(cols_raw);
        end

        h_raw = HCMP_W'({height_reg[HEIGHT_W-1:1], 1'b0});
        if (h_raw < H_MIN) begin
            h_eff = HW'(H_MIN);
        end else if (h_raw > H_CAP) begin
            h_eff = HW'(H_CAP);
        end else begin
            h_eff = HW'(h_raw);
        end

        rows_eff = ({1'b0, h_eff} + (HW+1)'(15)) >> 4;

        wh_full     = WH_W'(cols_eff * h_eff) << 4;
        base_u_next = wh_full[ADDR_W-1:0];
        base_v_next = ADDR_W'(wh_full + (wh_full >> 2));
    end

    // ---------------- counters ----------------
    always_comb begin
        accept   = s_tvalid && s_tready;
        in_kind  = s_tuser[0];
        in_start = s_tuser[1];

        l_col_cur = in_start ? '0 : l_col_reg;
        l_row_cur = in_start ? '0 : l_row_reg;
        l_off_cur = in_start ? '0 : l_off_reg;
        c_col_cur = in_start ? '0 : c_col_reg;
        c_row_cur = in_start ? '0 : c_row_reg;
        c_off_cur = in_start ? '0 : c_off_reg;

        col_sel = in_kind ? c_col_cur : l_col_cur;
        row_sel = in_kind ? c_row_cur : l_row_cur;
        off_sel = in_kind ? {1'b0, c_off_cur} : l_off_cur;
        mb_end  = in_kind ? (c_off_cur == 7'h7F) : (l_off_cur == 8'hFF);

        col_inc  = {1'b0, col_sel} + 1'b1;
        row_inc  = {1'b0, row_sel} + 1'b1;
        col_wrap = (CW+1)'(col_inc) >= (CW+1)'(cols_eff);
        row_wrap = (HW+1)'(row_inc) >= rows_eff;

        col_adv  = col_wrap ? '0 : col_inc[LCOL_W-1:0];
        row_adv  = col_wrap ? (row_wrap ? '0 : row_inc[ROW_W-1:0]) : row_sel;
        done_cur = in_kind && mb_end && col_wrap && row_wrap;

        l_col_next = l_col_reg;
        l_row_next = l_row_reg;
        l_off_next = l_off_reg;
        c_col_next = c_col_reg;
        c_row_next = c_row_reg;
        c_off_next = c_off_reg;
        if (accept) begin
            if (in_kind) begin
                c_off_next = c_off_cur + 7'd1;
                c_col_next = mb_end ? col_adv : c_col_cur;
                c_row_next = mb_end ? row_adv : c_row_cur;
            end else begin
                l_off_next = l_off_cur + 8'd1;
                l_col_next = mb_end ? col_adv : l_col_cur;
                l_row_next = mb_end ? row_adv : l_row_cur;
            end
        end
    end

    // ---------------- pipeline control ----------------
    always_comb begin
        out_ready     = !m_valid_reg || m_tready;
        s1_adv        = s1_valid_reg && out_ready;
        s_tready      = !s1_valid_reg || out_ready;
        s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        m_valid_next  = s1_adv ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    // ---------------- address ----------------
    always_comb begin
        y_luma = {s1_row_reg, s1_off_reg[7], s1_off_reg[5:3]};
        x_luma = {s1_col_reg, s1_off_reg[6], s1_off_reg[2:0]};
        cy     = {s1_row_reg, s1_off_reg[5:3]};
        cx     = {s1_col_reg, s1_off_reg[2:0]};

        mul_a = s1_kind_reg ? {1'b0, cy} : y_luma;
        prod  = mul_a * cols_eff;

        if (s1_kind_reg) begin
            term     = ADDR_W'(prod) << 3;
            base_sel = s1_off_reg[6] ? base_v_reg : base_u_reg;
            x_add    = ADDR_W'(cx);
            in_frame_calc = (YW'(cy) < YW'(h_eff >> 1)) &&
                            ((CW+1)'(s1_col_reg) < (CW+1)'(cols_eff));
        end else begin
            term     = ADDR_W'(prod) << 4;
            base_sel = '0;
            x_add    = ADDR_W'(x_luma);
            in_frame_calc = (YW'(y_luma) < YW'(h_eff)) &&
                            ((CW+1)'(s1_col_reg) < (CW+1)'(cols_eff));
        end
        addr_calc = base_sel + term + x_add;
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mb_cols_reg  <= MB_COLS_RST;
            height_reg   <= HEIGHT_RST;
            l_col_reg    <= '0;
            l_row_reg    <= '0;
            l_off_reg    <= '0;
            c_col_reg    <= '0;
            c_row_reg    <= '0;
            c_off_reg    <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            mb_cols_reg  <= mb_cols_next;
            height_reg   <= height_next;
            l_col_reg    <= l_col_next;
            l_row_reg    <= l_row_next;
            l_off_reg    <= l_off_next;
            c_col_reg    <= c_col_next;
            c_row_reg    <= c_row_next;
            c_off_reg    <= c_off_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_u_reg <= base_u_next;
        base_v_reg <= base_v_next;
        if (accept) begin
            s1_kind_reg <= in_kind;
            s1_off_reg  <= off_sel;
            s1_col_reg  <= col_sel;
            s1_row_reg  <= row_sel;
            s1_pix_reg  <= s_tdata[PIX_W-1:0];
            s1_done_reg <= done_cur;
        end
        if (s1_adv) begin
            addr_reg     <= addr_calc;
            pix_reg      <= s1_pix_reg;
            in_frame_reg <= in_frame_calc;
            done_reg     <= s1_done_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({pix_reg, addr_reg});
    assign m_tuser  = in_frame_reg;
    assign m_tlast  = done_reg;

endmodule

### rtl/tyi420_chk.sv
// Port-level checker for tiled_yuv_to_planar_i420_unit, with its bind.
// Uses tyi420_pkg for port widths.
module tyi420_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tyi420_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                              m_tuser,
    input logic                              m_tlast
);
    import tyi420_pkg::*;

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // an empty output stage never blocks the input
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // accepted transaction reaches the output through the input and output registers without stall
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("result missing after transaction");

endmodule

bind tiled_yuv_to_planar_i420_unit tyi420_chk u_tyi420_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
